/* src/usis_pkg.sv */
// ----------------------------------------------------------------------------
// Unsorted integer set package
// Shared widths, request codes, controller states and the memory request type.
// ----------------------------------------------------------------------------
package usis_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int OP_W        = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_FETCH,
      ST_MOVE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

endpackage

/* src/usis_if.sv */
// ----------------------------------------------------------------------------
// Unsorted integer set channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface usis_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface usis_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [3:0] position;
   logic       changed;
   logic [4:0] element_count;
   logic       is_full;

   modport source (output valid, output found, output position, output changed,
                   output element_count, output is_full, input ready);
   modport sink   (input valid, input found, input position, input changed,
                   input element_count, input is_full, output ready);
endinterface

/* src/usis_mem.sv */
// ----------------------------------------------------------------------------
// Entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module usis_mem (
   input  logic                         clock,
   input  usis_pkg::mem_req_type        mem_req,
   output logic [usis_pkg::DATA_W-1:0]  rd_data
);
   import usis_pkg::*;

   logic [DATA_W-1:0] mem_ar [TABLE_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ar[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ar[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/usis_ctrl.sv */
// ----------------------------------------------------------------------------
// Set controller
// Scans the live entries through the store for lookup, add and remove, applies
// the request and holds the response in an output register.
// ----------------------------------------------------------------------------
module usis_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [usis_pkg::CNT_W-1:0]   cap_eff,
   input  logic [usis_pkg::DATA_W-1:0]  rd_data,
   output usis_pkg::mem_req_type        mem_req,
   usis_req_if.sink                     req_if,
   usis_rsp_if.source                   rsp_if
);
   import usis_pkg::*;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic               changed_ff, changed_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic               rsp_chg_ff, rsp_chg_in;
   logic [CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic               rsp_full_ff, rsp_full_in;

   logic req_acc;
   logic issue;
   logic cmp_hit;
   logic add_ok;
   logic rem_ok;
   logic rsp_load;

   // status terms
   assign req_acc = req_if.valid && req_if.ready;
   assign issue   = (rd_idx_ff < count_ff);
   assign cmp_hit = cmp_vld_ff && (rd_data == value_ff);
   assign add_ok  = (op_ff == OP_ADD) && !hit_ff && (count_ff < cap_eff)
                    && (count_ff < CNT_W'(TABLE_DEPTH));
   assign rem_ok  = (op_ff == OP_REMOVE) && hit_ff && (count_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               state_in = (op_type'(req_if.operation) == OP_CLEAR) ? ST_APPLY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_hit || (!issue && !cmp_vld_ff)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = rem_ok ? ST_FETCH : ST_RESP;
         end
         ST_FETCH: state_in = ST_MOVE;
         ST_MOVE:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake and store access
   always_comb begin
      req_if.ready  = 1'b0;
      rsp_load      = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.waddr = count_ff[IDX_W-1:0];
      mem_req.wdata = value_ff;
      mem_req.raddr = rd_idx_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE:  req_if.ready = 1'b1;
         ST_SCAN:  mem_req.raddr = rd_idx_ff[IDX_W-1:0];
         ST_APPLY: mem_req.we = add_ok;
         ST_FETCH: mem_req.raddr = count_ff[IDX_W-1:0];
         ST_MOVE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_ff;
            mem_req.wdata = rd_data;
         end
         ST_RESP:  rsp_load = !rsp_vld_ff || rsp_if.ready;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in      = op_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      hit_in     = hit_ff;
      slot_in    = slot_ff;
      changed_in = changed_ff;

      // latch the request and restart the scan
      if (req_acc) begin
         op_in      = op_type'(req_if.operation);
         value_in   = req_if.value;
         rd_idx_in  = '0;
         cmp_vld_in = 1'b0;
         hit_in     = 1'b0;
         slot_in    = '0;
         changed_in = 1'b0;
      end

      // advance the scan: one read issued and one compare per cycle
      if (state_ff == ST_SCAN) begin
         cmp_vld_in = issue && !cmp_hit;
         cmp_idx_in = rd_idx_ff[IDX_W-1:0];
         if (issue) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         if (cmp_hit) begin
            hit_in  = 1'b1;
            slot_in = cmp_idx_ff;
         end
      end

      // apply the request to the count
      if (state_ff == ST_APPLY) begin
         if (add_ok) begin
            count_in   = count_ff + CNT_W'(1);
            changed_in = 1'b1;
         end else if (rem_ok) begin
            count_in   = count_ff - CNT_W'(1);
            changed_in = 1'b1;
         end else if (op_ff == OP_CLEAR) begin
            count_in   = '0;
            changed_in = (count_ff != '0);
         end
      end
   end

   // response register: take a new response when empty or being drained
   always_comb begin
      rsp_vld_in   = rsp_load || (rsp_vld_ff && !rsp_if.ready);
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_load) begin
         rsp_found_in = hit_ff;
         rsp_pos_in   = hit_ff ? slot_ff : '0;
         rsp_chg_in   = changed_ff;
         rsp_cnt_in   = count_ff;
         rsp_full_in  = (count_ff >= cap_eff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      slot_ff      <= slot_in;
      changed_ff   <= changed_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.position      = rsp_pos_ff;
   assign rsp_if.changed       = rsp_chg_ff;
   assign rsp_if.element_count = rsp_cnt_ff;
   assign rsp_if.is_full       = rsp_full_ff;

endmodule

/* src/unsorted_int_set_table_top.sv */
// Flow: a clear goes from idle through apply to the response register; lookup,
// add and remove first scan the live entries one per cycle through the store's
// single read port, and a remove that hits then fetches and moves the last entry.
// The block takes one request at a time.
// Reset: count cleared, capacity register set to 16, entries left unwritten.
// ----------------------------------------------------------------------------
// Unsorted integer set table
// Capacity register, entry store and set controller.
// ----------------------------------------------------------------------------
module unsorted_int_set_table_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [usis_pkg::CNT_W-1:0]  csr_wdata,
   usis_req_if.sink                    req_if,
   usis_rsp_if.source                  rsp_if
);
   import usis_pkg::*;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  cap_eff;
   logic [DATA_W-1:0] rd_data;
   mem_req_type       mem_req;

   // capacity register, clipped to the table depth
   assign cap_in  = csr_we ? csr_wdata : cap_ff;
   assign cap_eff = (cap_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CNT_W'(TABLE_DEPTH);
      end else begin
         cap_ff <= cap_in;
      end
   end

   usis_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   usis_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cap_eff (cap_eff),
      .rd_data (rd_data),
      .mem_req (mem_req),
      .req_if  (req_if),
      .rsp_if  (rsp_if)
   );

   // one request in flight: no new request right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while another is in flight");

   // count never exceeds the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.element_count <= CNT_W'(TABLE_DEPTH))
      else $error("element count beyond table depth");

   // a miss reports slot zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.found |-> rsp_if.position == '0)
      else $error("nonzero position on a miss");

   // stores only happen outside idle
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> !req_if.ready)
      else $error("store written while idle");

endmodule

/* verif/usis_set_checker.sv */
// ----------------------------------------------------------------------------
// Unsorted integer set checker
// Watches the capacity port and both channels, keeps its own copy of the set,
// predicts one response per accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module usis_set_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [usis_pkg::CNT_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [usis_pkg::OP_W-1:0]    req_operation,
   input  logic [usis_pkg::DATA_W-1:0]  req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_found,
   input  logic [usis_pkg::IDX_W-1:0]   rsp_position,
   input  logic                         rsp_changed,
   input  logic [usis_pkg::CNT_W-1:0]   rsp_element_count,
   input  logic                         rsp_is_full,
   output int                           fail_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import usis_pkg::*;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
      logic             changed;
      logic [CNT_W-1:0] element_count;
      logic             is_full;
   } set_result_type;

   // Shadow copy of the set and the capacity register
   logic [DATA_W-1:0] shadow_entries [TABLE_DEPTH];
   int unsigned       shadow_count;
   logic [CNT_W-1:0]  shadow_capacity;
   set_result_type    expected_rsp_q [$];
   int                rsp_seen;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      rsp_seen      = 0;
      shadow_count  = 0;
      shadow_capacity = CNT_W'(TABLE_DEPTH);
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
   end

   // Apply one request to the shadow set and return the response it causes
   function automatic set_result_type apply_set_request(input op_type op,
                                                        input logic [DATA_W-1:0] v);
      set_result_type res;
      int unsigned    limit;
      int unsigned    slot;
      bit             hit;
      res   = '0;
      hit   = 1'b0;
      slot  = 0;
      limit = (shadow_capacity > TABLE_DEPTH) ? TABLE_DEPTH : shadow_capacity;
      // the scan stops at the first live slot holding the value
      if (op != OP_CLEAR) begin
         for (int i = 0; i < shadow_count; i++) begin
            if (!hit && shadow_entries[i] == v) begin
               hit  = 1'b1;
               slot = i;
            end
         end
      end
      case (op)
         OP_ADD: begin
            if (!hit && shadow_count < limit && shadow_count < TABLE_DEPTH) begin
               shadow_entries[shadow_count] = v;
               shadow_count++;
               res.changed = 1'b1;
            end
         end
         OP_REMOVE: begin
            // move the last live entry into the freed slot
            if (hit && shadow_count > 0) begin
               shadow_count--;
               shadow_entries[slot] = shadow_entries[shadow_count];
               res.changed = 1'b1;
            end
         end
         OP_CLEAR: begin
            res.changed  = (shadow_count != 0);
            shadow_count = 0;
         end
         default: ;
      endcase
      res.found         = hit;
      res.position      = hit ? IDX_W'(slot) : '0;
      res.element_count = CNT_W'(shadow_count);
      res.is_full       = (shadow_count >= limit);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] response %0d: %s got %0d expected %0d",
               $realtime, rsp_seen, what, got, want);
      fail_count++;
   endtask

   task automatic check_response();
      set_result_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("response with no request outstanding", 1, 0);
         return;
      end
      want = expected_rsp_q.pop_front();
      if (rsp_found !== want.found)
         report_mismatch("found", rsp_found, want.found);
      if (rsp_position !== want.position)
         report_mismatch("position", rsp_position, want.position);
      if (rsp_changed !== want.changed)
         report_mismatch("changed", rsp_changed, want.changed);
      if (rsp_element_count !== want.element_count)
         report_mismatch("element_count", rsp_element_count, want.element_count);
      if (rsp_is_full !== want.is_full)
         report_mismatch("is_full", rsp_is_full, want.is_full);
   endtask

   // Track the register, predict on request, compare on response
   always @(posedge clock) begin
      if (reset) begin
         expected_rsp_q.delete();
         shadow_count    = 0;
         shadow_capacity = CNT_W'(TABLE_DEPTH);
      end else begin
         if (csr_we)
            shadow_capacity = csr_wdata;
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_set_request(op_type'(req_operation), req_value));
         if (rsp_valid && rsp_ready) begin
            check_response();
            rsp_seen++;
         end
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

/* verif/unsorted_int_set_table_top_tb.sv */
// ----------------------------------------------------------------------------
// Unsorted integer set table testbench
// Drives directed and random lookup/add/remove/clear requests across several
// capacity settings with random stalls on both channels; the checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module unsorted_int_set_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import usis_pkg::*;

   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 172;
   localparam int STEADY_ITEMS    = 40;
   localparam int HOLD_CYCLES     = 250;
   localparam int HOLD_PHASE      = 2;
   localparam int POOL_SIZE       = 24;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;

   usis_req_if req_ch ();
   usis_rsp_if rsp_ch ();

   int fail_total;
   int pending_results;
   int idle_cycles = 0;

   // Shared between the sender and the receiver process
   bit rsp_steady   = 1'b0;
   bit rsp_hold_req = 1'b0;

   logic [DATA_W-1:0] value_pool [POOL_SIZE];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   unsorted_int_set_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   usis_set_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_operation     (req_ch.operation),
      .req_value         (req_ch.value),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_found         (rsp_ch.found),
      .rsp_position      (rsp_ch.position),
      .rsp_changed       (rsp_ch.changed),
      .rsp_element_count (rsp_ch.element_count),
      .rsp_is_full       (rsp_ch.is_full),
      .fail_count        (fail_total),
      .pending_count     (pending_results)
   );

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one request and hold it until accepted; call just after the clock rises
   task automatic send_request(input op_type op, input logic [DATA_W-1:0] v,
                               input bit allow_gap);
      int unsigned gap;
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = allow_gap ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request(input bit allow_gap);
      op_type            op;
      logic [DATA_W-1:0] v;
      int unsigned       r;
      r = $urandom_range(0, 99);
      if (r < 30)      op = OP_LOOKUP;
      else if (r < 65) op = OP_ADD;
      else if (r < 96) op = OP_REMOVE;
      else             op = OP_CLEAR;
      // draw mostly from the pool so adds and removes hit stored values
      if ($urandom_range(0, 4) != 0) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      else                           v = $urandom;
      send_request(op, v, allow_gap);
   endtask

   // Hold off the sender until every outstanding response has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random stalls, steady stretches and one long hold-off
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!rsp_steady) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [CNT_W-1:0] cap_plan [PHASES];
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_LOOKUP;
      req_ch.value     <= '0;
      cap_plan = '{5'd31, 5'd0, 5'd1, 5'd5, 5'd16, 5'd20, 5'd3, 5'd16};
      cap_plan[6] = CNT_W'($urandom_range(0, 31));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty lookup, extreme values, duplicate add, absent
      // remove, remove with a move of the last entry, overfill, clears
      send_request(OP_LOOKUP, 32'h8000_0000, 1'b1);
      send_request(OP_ADD,    32'h8000_0000, 1'b1);
      send_request(OP_ADD,    32'h7FFF_FFFF, 1'b1);
      send_request(OP_ADD,    32'h0000_0000, 1'b1);
      send_request(OP_ADD,    32'hFFFF_FFFF, 1'b1);
      send_request(OP_ADD,    32'h7FFF_FFFF, 1'b1);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
      send_request(OP_LOOKUP, 32'h0000_0005, 1'b1);
      send_request(OP_REMOVE, 32'h0000_0005, 1'b1);
      send_request(OP_REMOVE, 32'h8000_0000, 1'b1);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1);
      for (int k = 0; k < 13; k++)
         send_request(OP_ADD, 32'h5A5A_0000 + k, 1'b0);
      send_request(OP_ADD,    32'h1234_5678, 1'b1);
      send_request(OP_LOOKUP, 32'h5A5A_000C, 1'b1);
      send_request(OP_CLEAR,  32'h0000_0000, 1'b1);
      send_request(OP_CLEAR,  32'hFFFF_FFFF, 1'b1);
      wait_drained();

      // Random phases, one capacity setting each; the set carries over
      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(cap_plan[phase]);
         value_pool[0] = 32'h8000_0000;
         value_pool[1] = 32'h7FFF_FFFF;
         value_pool[2] = 32'h0000_0000;
         value_pool[3] = 32'hFFFF_FFFF;
         for (int p = 4; p < POOL_SIZE; p++) value_pool[p] = $urandom;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            rsp_steady = (n < STEADY_ITEMS);
            if (phase == HOLD_PHASE && n == STEADY_ITEMS + 20)
               rsp_hold_req = 1'b1;
            // keep offering back to back in the steady stretch and while the receiver holds off
            send_random_request(!(n < STEADY_ITEMS ||
                                  (phase == HOLD_PHASE && n >= STEADY_ITEMS + 20 &&
                                   n < STEADY_ITEMS + 40)));
         end
         rsp_steady = 1'b0;
         wait_drained();
      end

      if (fail_total == 0 && pending_results == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
